### rtl/assert_macros.svh
// Assertion macros used by the result table top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/dhrt_pkg.sv
// Package with shared constants and types of the result table
package dhrt_pkg;
    localparam int TABLE_BITS  = 12;
    localparam int TABLE_DEPTH = 1 << TABLE_BITS;
    localparam int ENTRY_W     = 112;

    localparam logic [1:0] REQ_RECORD  = 2'd0;
    localparam logic [1:0] REQ_MERGE   = 2'd1;
    localparam logic [1:0] REQ_QUERY   = 2'd2;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DEEP     = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [1:0] OC_WHITE = 2'd0;
    localparam logic [1:0] OC_BLACK = 2'd1;
    localparam logic [1:0] OC_DRAW  = 2'd2;
    localparam logic [1:0] OC_NONE  = 2'd3;

    localparam logic CFG_BITS = 1'b0;
    localparam logic CFG_PLY  = 1'b1;

    // divider handshake
    typedef struct packed {
        logic        start;
        logic [23:0] dividend;
        logic [17:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [23:0] quotient;
    } t_div_rsp;
endpackage

### rtl/dhrt_ram.sv
// Generic single-port RAM with registered read
module dhrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### rtl/dhrt_div.sv
// Restoring divider, one quotient bit per cycle
module dhrt_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dhrt_pkg::t_div_req i_req,
    output dhrt_pkg::t_div_rsp o_rsp
);
    logic [23:0] r_quo, n_quo;
    logic [18:0] r_rem, n_rem;
    logic [17:0] r_dvs;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [18:0] w_trial;

    always_comb begin
        w_trial = {r_rem[17:0], r_quo[23]};
        n_quo   = {r_quo[22:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_dvs}) begin
            n_rem    = w_trial - {1'b0, r_dvs};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd23) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

### rtl/double_hash_result_table.sv
// Top level of the double-hashed result table
// One request is in work at a time. After reset a clearing pass writes all
// 4096 entries, one per cycle, before the first request is taken. Each probe
// of a request then steps through READ, WAIT and CHECK (RAM read, compare,
// step), and the request finishes in OUT; a query first runs the score
// division in the bit-serial divider. The single RAM port sets the probe rate.
`include "assert_macros.svh"
module double_hash_result_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [63:0] i_key,
    input  logic [7:0]  i_ply,
    input  logic [1:0]  i_outcome,
    input  logic        i_mover_white,
    input  logic [15:0] i_add_wins,
    input  logic [15:0] i_add_losses,
    input  logic [15:0] i_add_draws,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_was_present,
    output logic [15:0] o_wins_out,
    output logic [15:0] o_losses_out,
    output logic [15:0] o_draws_out,
    output logic [15:0] o_score_out,
    output logic [12:0] o_entries_used,
    output logic [31:0] o_collisions_total,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    localparam int AW = dhrt_pkg::TABLE_BITS;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]  r_state;
    logic [AW:0] r_clr;
    logic [3:0]  r_bits_cfg;
    logic [7:0]  r_max_ply;
    logic [31:0] r_used;
    logic [31:0] r_coll;

    logic [1:0]  r_req;
    logic [63:0] r_key;
    logic [1:0]  r_outc;
    logic        r_white;
    logic [15:0] r_aw, r_al, r_ad;
    logic [AW-1:0] r_slot, r_stride, r_mask;
    logic [AW:0]   r_nprobe, r_size;
    logic [12:0]   r_limit;

    logic [1:0]  r_st;
    logic        r_pres;
    logic [15:0] r_w, r_l, r_d, r_sc;
    logic        r_ovalid;

    logic        w_we;
    logic [AW-1:0] w_addr;
    logic [dhrt_pkg::ENTRY_W-1:0] w_wdata, w_rdata;

    dhrt_pkg::t_div_req w_dreq;
    dhrt_pkg::t_div_rsp w_drsp;

    // effective bits, clamped
    logic [3:0]    w_bits;
    logic [AW:0]   w_size;
    logic [AW-1:0] w_mask;
    always_comb begin
        w_bits = r_bits_cfg;
        if (w_bits == 4'd0) w_bits = 4'd1;
        if (w_bits > 4'(AW)) w_bits = 4'(AW);
        w_size = (AW+1)'(1) << w_bits;
        w_mask = AW'(w_size - (AW+1)'(1));
    end

    // fill limit: 95 percent of the table size, rounded down
    logic [12:0] w_limit;
    always_comb begin
        unique case (w_bits)
            4'd1:    w_limit = 13'd1;
            4'd2:    w_limit = 13'd3;
            4'd3:    w_limit = 13'd7;
            4'd4:    w_limit = 13'd15;
            4'd5:    w_limit = 13'd30;
            4'd6:    w_limit = 13'd60;
            4'd7:    w_limit = 13'd121;
            4'd8:    w_limit = 13'd243;
            4'd9:    w_limit = 13'd486;
            4'd10:   w_limit = 13'd972;
            4'd11:   w_limit = 13'd1945;
            default: w_limit = 13'd3891;
        endcase
    end

    // slot view
    logic [63:0] w_ekey;
    logic [15:0] w_ew, w_el, w_ed;
    logic        w_empty, w_match;
    assign {w_ekey, w_ew, w_el, w_ed} = w_rdata;
    assign w_empty = (w_ekey == 64'd0) && (w_ew == 16'd0) && (w_el == 16'd0)
                     && (w_ed == 16'd0);
    assign w_match = (w_ekey == r_key);

    logic w_accept;
    assign w_accept = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_cfg_ready = 1'b1;

    // RAM port control
    always_comb begin
        w_we    = 1'b0;
        w_addr  = r_slot;
        w_wdata = {r_key, r_w, r_l, r_d};
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_addr  = r_clr[AW-1:0];
            w_wdata = '0;
        end else if (r_state == S_OUT && r_st == dhrt_pkg::ST_OK
                     && (r_req == dhrt_pkg::REQ_RECORD || r_req == dhrt_pkg::REQ_MERGE)) begin
            w_we = 1'b1;
        end
    end

    dhrt_ram #(.WIDTH(dhrt_pkg::ENTRY_W), .DEPTH(dhrt_pkg::TABLE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    // score division
    always_comb begin
        w_dreq.start    = (r_state == S_CHECK) && (r_req == dhrt_pkg::REQ_QUERY)
                          && (w_empty ? 1'b0 : w_match);
        w_dreq.dividend = 24'd100 * (24'(w_ew) + 24'(w_ed[15:1]));
        w_dreq.divisor  = 18'(w_ew) + 18'(w_el) + 18'(w_ed);
        if (w_dreq.divisor == 18'd0) w_dreq.divisor = 18'd1;
    end

    dhrt_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    // credit for record
    logic [15:0] w_cw, w_cl, w_cd;
    always_comb begin
        w_cw = w_ew; w_cl = w_el; w_cd = w_ed;
        if (r_outc == dhrt_pkg::OC_DRAW) w_cd = w_ed + 16'd1;
        else if ((r_outc == dhrt_pkg::OC_WHITE && r_white)
                 || (r_outc == dhrt_pkg::OC_BLACK && !r_white)) w_cw = w_ew + 16'd1;
        else if (r_outc == dhrt_pkg::OC_WHITE || r_outc == dhrt_pkg::OC_BLACK)
            w_cl = w_el + 16'd1;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_bits_cfg <= 4'd12;
            r_max_ply  <= 8'd24;
            r_used     <= '0;
            r_coll     <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == dhrt_pkg::CFG_BITS) r_bits_cfg <= i_cfg_data[3:0];
                else r_max_ply <= i_cfg_data;
            end
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + (AW+1)'(1);
                    if (r_clr == (AW+1)'(dhrt_pkg::TABLE_DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_req    <= i_req_type;
                        r_key    <= i_key;
                        r_outc   <= i_outcome;
                        r_white  <= i_mover_white;
                        r_aw     <= i_add_wins;
                        r_al     <= i_add_losses;
                        r_ad     <= i_add_draws;
                        r_mask   <= w_mask;
                        r_size   <= w_size;
                        r_slot   <= i_key[AW-1:0] & w_mask;
                        r_stride <= AW'((i_key >> w_bits) | 64'd1) & w_mask;
                        r_limit  <= w_limit;
                        r_nprobe <= '0;
                        r_pres   <= 1'b0;
                        r_w <= '0; r_l <= '0; r_d <= '0; r_sc <= '0;
                        r_st     <= dhrt_pkg::ST_OK;
                        if (i_req_type == dhrt_pkg::REQ_UNKNOWN) begin
                            r_state <= S_OUT;
                        end else if (i_req_type == dhrt_pkg::REQ_RECORD
                                     && i_ply > r_max_ply) begin
                            r_st    <= dhrt_pkg::ST_DEEP;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    if (r_nprobe == r_size) begin
                        r_st    <= dhrt_pkg::ST_FULL;
                        r_req   <= dhrt_pkg::REQ_QUERY;
                        r_w <= '0; r_l <= '0; r_d <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: r_state <= S_CHECK;
                S_CHECK: begin
                    r_nprobe <= r_nprobe + (AW+1)'(1);
                    r_state  <= S_OUT;
                    r_w <= w_ew; r_l <= w_el; r_d <= w_ed;
                    if (r_req == dhrt_pkg::REQ_RECORD) begin
                        if (w_match) begin
                            r_pres <= 1'b1;
                            r_w <= w_cw; r_l <= w_cl; r_d <= w_cd;
                        end else if (w_empty) begin
                            if (r_used <= 32'(r_limit)) begin
                                r_used <= r_used + 32'd1;
                                r_w <= w_cw; r_l <= w_cl; r_d <= w_cd;
                            end else begin
                                r_st <= dhrt_pkg::ST_FULL;
                                r_req <= dhrt_pkg::REQ_QUERY;
                                r_w <= '0; r_l <= '0; r_d <= '0;
                            end
                        end else begin
                            r_coll  <= r_coll + 32'd1;
                            r_slot  <= (r_slot + r_stride) & r_mask;
                            r_state <= S_READ;
                        end
                    end else if (r_req == dhrt_pkg::REQ_MERGE) begin
                        if (w_empty || w_match) begin
                            r_pres <= !w_empty;
                            if (w_empty) r_used <= r_used + 32'd1;
                            r_w <= w_ew + r_aw; r_l <= w_el + r_al; r_d <= w_ed + r_ad;
                        end else begin
                            r_coll  <= r_coll + 32'd1;
                            r_slot  <= (r_slot + r_stride) & r_mask;
                            r_state <= S_READ;
                        end
                    end else begin
                        if (w_empty) begin
                            r_st <= dhrt_pkg::ST_NOTFOUND;
                            r_w <= '0; r_l <= '0; r_d <= '0;
                        end else if (w_match) begin
                            r_pres  <= 1'b1;
                            r_state <= S_DIV;
                        end else begin
                            r_slot  <= (r_slot + r_stride) & r_mask;
                            r_state <= S_READ;
                        end
                    end
                end
                S_DIV: begin
                    if (w_drsp.done) begin
                        r_sc    <= 16'(w_drsp.quotient + 24'(r_w[15:1]));
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid            = r_ovalid;
    assign o_status           = r_st;
    assign o_was_present      = r_pres;
    assign o_wins_out         = r_w;
    assign o_losses_out       = r_l;
    assign o_draws_out        = r_d;
    assign o_score_out        = r_sc;
    assign o_entries_used     = r_used[12:0];
    assign o_collisions_total = r_coll;

    // checks
    `ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, o_valid && o_status != dhrt_pkg::ST_OK,
                 !o_was_present && o_wins_out == 16'd0 && o_score_out == 16'd0)
    `ASSERT_IMPL(a_probe_bound, i_clk, i_rst_n, r_state == S_CHECK, r_nprobe < r_size)
    `ASSERT_NEXT(a_one_item, i_clk, i_rst_n, w_accept, !o_ready)
    `ASSERT_IMPL(a_no_write_busy, i_clk, i_rst_n, w_we && r_state != S_CLEAR,
                 r_state == S_OUT)
endmodule

### tb/sv/dhrt_checker.sv
// Checker for the result table: predicts each request and compares the results
module dhrt_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [63:0] i_key,
    input  logic [7:0]  i_ply,
    input  logic [1:0]  i_outcome,
    input  logic        i_mover_white,
    input  logic [15:0] i_add_wins,
    input  logic [15:0] i_add_losses,
    input  logic [15:0] i_add_draws,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [1:0]  o_status,
    input  logic        o_was_present,
    input  logic [15:0] o_wins_out,
    input  logic [15:0] o_losses_out,
    input  logic [15:0] o_draws_out,
    input  logic [15:0] o_score_out,
    input  logic [12:0] o_entries_used,
    input  logic [31:0] o_collisions_total,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output int          fail_count,
    output int          pending
);
    typedef struct packed {
        logic [1:0]  status;
        logic        present;
        logic [15:0] wins;
        logic [15:0] losses;
        logic [15:0] draws;
        logic [15:0] score;
        logic [12:0] used;
        logic [31:0] collisions;
    } t_table_result;

    // shadow copy of the table
    logic [63:0] shadow_keys   [dhrt_pkg::TABLE_DEPTH];
    logic [15:0] shadow_wins   [dhrt_pkg::TABLE_DEPTH];
    logic [15:0] shadow_losses [dhrt_pkg::TABLE_DEPTH];
    logic [15:0] shadow_draws  [dhrt_pkg::TABLE_DEPTH];
    logic [31:0] used_entries;
    logic [31:0] collision_tally;
    logic [3:0]  index_bits;
    logic [7:0]  ply_limit;

    t_table_result expected_results[$];

    initial begin
        for (int i = 0; i < dhrt_pkg::TABLE_DEPTH; i++) begin
            shadow_keys[i]   = '0;
            shadow_wins[i]   = '0;
            shadow_losses[i] = '0;
            shadow_draws[i]  = '0;
        end
        used_entries    = 0;
        collision_tally = 0;
        index_bits      = 4'd12;
        ply_limit       = 8'd24;
        fail_count      = 0;
    end

    assign pending = expected_results.size();

    function automatic bit is_vacant(int unsigned s);
        return shadow_keys[s] == 0 && shadow_wins[s] == 0 &&
               shadow_losses[s] == 0 && shadow_draws[s] == 0;
    endfunction

    // work out the result of one request and update the shadow table
    task automatic predict_request(input logic [1:0] req, input logic [63:0] key,
                                   input logic [7:0] ply, input logic [1:0] oc,
                                   input logic white, input logic [15:0] aw,
                                   input logic [15:0] al, input logic [15:0] ad);
        int unsigned bits, size, mask, fill_cap, stride, s, tot, w, l, d;
        logic [1:0] st;
        bit present, done;
        t_table_result r;
        bits = 32'(index_bits);
        if (bits < 1) bits = 1;
        if (bits > 32'(dhrt_pkg::TABLE_BITS)) bits = 32'(dhrt_pkg::TABLE_BITS);
        size     = 32'd1 << bits;
        mask     = size - 32'd1;
        fill_cap = (32'd95 * size) / 32'd100;
        stride   = 32'(((key >> bits) | 64'd1) & 64'(mask));
        s        = 32'(key & 64'(mask));
        st = dhrt_pkg::ST_OK;
        present = 0;
        done = 0;
        w = 0; l = 0; d = 0;
        r.score = '0;
        if (req == dhrt_pkg::REQ_RECORD) begin
            if (ply > ply_limit) begin
                st = dhrt_pkg::ST_DEEP;
            end else begin
                st = dhrt_pkg::ST_FULL;
                for (int unsigned n = 0; n < size && !done; n++) begin
                    if (shadow_keys[s] == key) begin
                        present = 1; st = dhrt_pkg::ST_OK; done = 1;
                    end else if (is_vacant(s)) begin
                        done = 1;
                        if (used_entries <= fill_cap) begin
                            shadow_keys[s] = key;
                            used_entries++;
                            st = dhrt_pkg::ST_OK;
                        end
                    end else begin
                        collision_tally++;
                        s = (s + stride) & mask;
                    end
                end
                if (st == dhrt_pkg::ST_OK) begin
                    if (oc == dhrt_pkg::OC_DRAW) shadow_draws[s]++;
                    else if ((oc == dhrt_pkg::OC_WHITE && white)
                             || (oc == dhrt_pkg::OC_BLACK && !white))
                        shadow_wins[s]++;
                    else if (oc == dhrt_pkg::OC_WHITE || oc == dhrt_pkg::OC_BLACK)
                        shadow_losses[s]++;
                end
            end
        end else if (req == dhrt_pkg::REQ_MERGE) begin
            st = dhrt_pkg::ST_FULL;
            for (int unsigned n = 0; n < size && !done; n++) begin
                if (shadow_keys[s] == key && !is_vacant(s)) begin
                    present = 1; st = dhrt_pkg::ST_OK; done = 1;
                end else if (is_vacant(s)) begin
                    st = dhrt_pkg::ST_OK; done = 1;
                    used_entries++;
                end else begin
                    collision_tally++;
                    s = (s + stride) & mask;
                end
            end
            if (st == dhrt_pkg::ST_OK) begin
                shadow_keys[s]   = key;
                shadow_wins[s]   = shadow_wins[s] + aw;
                shadow_losses[s] = shadow_losses[s] + al;
                shadow_draws[s]  = shadow_draws[s] + ad;
            end
        end else if (req == dhrt_pkg::REQ_QUERY) begin
            st = dhrt_pkg::ST_FULL;
            for (int unsigned n = 0; n < size && !done; n++) begin
                if (is_vacant(s)) begin
                    st = dhrt_pkg::ST_NOTFOUND; done = 1;
                end else if (shadow_keys[s] == key) begin
                    present = 1; st = dhrt_pkg::ST_OK; done = 1;
                end else begin
                    s = (s + stride) & mask;
                end
            end
        end
        // unknown request types fall through with status ok and zero counts
        if (st == dhrt_pkg::ST_OK && req != dhrt_pkg::REQ_UNKNOWN) begin
            w = 32'(shadow_wins[s]); l = 32'(shadow_losses[s]); d = 32'(shadow_draws[s]);
            if (req == dhrt_pkg::REQ_QUERY) begin
                tot = w + l + d;
                if (tot == 0) tot = 1;
                r.score = 16'((32'd100 * (w + d / 32'd2)) / tot + w / 32'd2);
            end
        end
        if (st != dhrt_pkg::ST_OK) present = 0;
        r.status     = st;
        r.present    = present;
        r.wins       = 16'(w);
        r.losses     = 16'(l);
        r.draws      = 16'(d);
        r.used       = used_entries[12:0];
        r.collisions = collision_tally;
        expected_results.push_back(r);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // watch the three channels
    always @(posedge i_clk) begin
        t_table_result e;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    report("unexpected result transfer", 32'd0, 32'd0);
                end else begin
                    e = expected_results.pop_front();
                    if (o_status !== e.status)
                        report("status", 32'(o_status), 32'(e.status));
                    if (o_was_present !== e.present)
                        report("was_present", 32'(o_was_present), 32'(e.present));
                    if (o_wins_out !== e.wins)
                        report("wins", 32'(o_wins_out), 32'(e.wins));
                    if (o_losses_out !== e.losses)
                        report("losses", 32'(o_losses_out), 32'(e.losses));
                    if (o_draws_out !== e.draws)
                        report("draws", 32'(o_draws_out), 32'(e.draws));
                    if (o_score_out !== e.score)
                        report("score", 32'(o_score_out), 32'(e.score));
                    if (o_entries_used !== e.used)
                        report("entries_used", 32'(o_entries_used), 32'(e.used));
                    if (o_collisions_total !== e.collisions)
                        report("collisions", o_collisions_total, e.collisions);
                end
            end
            if (i_valid && o_ready)
                predict_request(i_req_type, i_key, i_ply, i_outcome, i_mover_white,
                                i_add_wins, i_add_losses, i_add_draws);
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == dhrt_pkg::CFG_BITS) index_bits = i_cfg_data[3:0];
                else ply_limit = i_cfg_data;
            end
        end
    end
endmodule

### tb/sv/double_hash_result_table_tb.sv
// Testbench top for the result table: stimulus, receiver stalls and verdict
module double_hash_result_table_tb;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_req_type = '0;
    logic [63:0] i_key = '0;
    logic [7:0]  i_ply = '0;
    logic [1:0]  i_outcome = '0;
    logic        i_mover_white = 1'b0;
    logic [15:0] i_add_wins = '0;
    logic [15:0] i_add_losses = '0;
    logic [15:0] i_add_draws = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic        o_was_present;
    logic [15:0] o_wins_out, o_losses_out, o_draws_out, o_score_out;
    logic [12:0] o_entries_used;
    logic [31:0] o_collisions_total;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [7:0]  i_cfg_data = '0;
    int          fail_count, pending;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int N_PHASES = 9;
    logic [7:0] phase_bits [N_PHASES] = '{8'd12, 8'd1, 8'd0, 8'd2, 8'd3, 8'd15, 8'd5,
                                          8'd4, 8'd12};
    logic [7:0] phase_ply  [N_PHASES] = '{8'd24, 8'd0, 8'd255, 8'd24, 8'd128, 8'd200,
                                          8'd24, 8'd7, 8'd255};
    logic [63:0] key_pool [12];
    logic [7:0]  cur_ply_limit = 8'd24;

    always #2 i_clk = ~i_clk;

    double_hash_result_table dut (.*);
    dhrt_checker checker_i (.*);

    // overall time guard
    int cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off to back up the block
    initial begin
        int taken, hold;
        taken = 0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) taken++;
            if (taken == 300 && hold == 0) begin
                i_ready <= 1'b0;
                for (hold = 0; hold < 600; hold++) @(posedge i_clk);
            end else if ($urandom_range(0, 99) < 20 && taken > 60) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(0, 99) < 90 ? $urandom_range(1, 3)
                                                   : $urandom_range(10, 60)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // offer one request and hold it until the transfer
    task automatic send(input logic [1:0] req, input logic [63:0] key, input logic [7:0] ply,
                        input logic [1:0] oc, input logic white, input logic [15:0] aw,
                        input logic [15:0] al, input logic [15:0] ad);
        int unsigned g;
        i_valid <= 1'b1;
        i_req_type <= req;
        i_key <= key;
        i_ply <= ply;
        i_outcome <= oc;
        i_mover_white <= white;
        i_add_wins <= aw;
        i_add_losses <= al;
        i_add_draws <= ad;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_count();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 60) return 16'($urandom_range(0, 5));
        if (p < 80) return 16'hFFFF - 16'($urandom_range(0, 3));
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic random_request();
        int unsigned p;
        logic [1:0] req;
        logic [63:0] key;
        logic [7:0] ply;
        p = $urandom_range(0, 99);
        req = p < 40 ? dhrt_pkg::REQ_RECORD : p < 65 ? dhrt_pkg::REQ_MERGE
            : p < 95 ? dhrt_pkg::REQ_QUERY : dhrt_pkg::REQ_UNKNOWN;
        key = $urandom_range(0, 99) < 80 ? key_pool[$urandom_range(0, 11)]
                                         : {$urandom(), $urandom()};
        ply = $urandom_range(0, 99) < 85 ? 8'($urandom_range(0, 32'(cur_ply_limit)))
                                         : 8'($urandom_range(0, 255));
        send(req, key, ply, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
             rand_count(), rand_count(), rand_count());
    endtask

    // stimulus
    initial begin
        for (int i = 0; i < 12; i++) key_pool[i] = {$urandom(), $urandom()};
        // keys sharing low bits so that probes collide in any table size
        key_pool[1] = {key_pool[0][63:12] ^ 52'h5, key_pool[0][11:0]};
        key_pool[2] = {key_pool[0][63:12] ^ 52'h9A, key_pool[0][11:0]};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset settings
        send(dhrt_pkg::REQ_QUERY, 64'd0, 8'd0, dhrt_pkg::OC_WHITE, 1'b1, 16'd0, 16'd0, 16'd0);
        send(dhrt_pkg::REQ_RECORD, 64'd0, 8'd0, dhrt_pkg::OC_WHITE, 1'b1, 16'd0, 16'd0, 16'd0);
        send(dhrt_pkg::REQ_RECORD, '1, 8'd24, dhrt_pkg::OC_WHITE, 1'b1, 16'd0, 16'd0, 16'd0);
        send(dhrt_pkg::REQ_RECORD, '1, 8'd25, dhrt_pkg::OC_BLACK, 1'b0, 16'd0, 16'd0, 16'd0);
        send(dhrt_pkg::REQ_RECORD, '1, 8'd255, dhrt_pkg::OC_DRAW, 1'b1, 16'd0, 16'd0, 16'd0);
        send(dhrt_pkg::REQ_RECORD, '1, 8'd3, dhrt_pkg::OC_BLACK, 1'b1, 16'd0, 16'd0, 16'd0);
        send(dhrt_pkg::REQ_RECORD, '1, 8'd3, dhrt_pkg::OC_BLACK, 1'b0, 16'd0, 16'd0, 16'd0);
        send(dhrt_pkg::REQ_RECORD, '1, 8'd3, dhrt_pkg::OC_WHITE, 1'b0, 16'd0, 16'd0, 16'd0);
        send(dhrt_pkg::REQ_RECORD, '1, 8'd3, dhrt_pkg::OC_DRAW, 1'b0, 16'd0, 16'd0, 16'd0);
        send(dhrt_pkg::REQ_RECORD, '1, 8'd3, dhrt_pkg::OC_NONE, 1'b1, 16'd0, 16'd0, 16'd0);
        send(dhrt_pkg::REQ_QUERY, '1, 8'd0, dhrt_pkg::OC_WHITE, 1'b0, 16'd0, 16'd0, 16'd0);
        send(dhrt_pkg::REQ_MERGE, key_pool[0], 8'd0, dhrt_pkg::OC_WHITE, 1'b0,
             16'hFFFF, 16'hFFFF, 16'hFFFF);
        send(dhrt_pkg::REQ_MERGE, key_pool[0], 8'd0, dhrt_pkg::OC_WHITE, 1'b0,
             16'h0002, 16'h0001, 16'h0003);
        send(dhrt_pkg::REQ_MERGE, key_pool[1], 8'd0, dhrt_pkg::OC_WHITE, 1'b0,
             16'hFFFF, 16'd0, 16'd0);
        send(dhrt_pkg::REQ_MERGE, key_pool[2], 8'd0, dhrt_pkg::OC_WHITE, 1'b0,
             16'd0, 16'd0, 16'd0);
        send(dhrt_pkg::REQ_MERGE, key_pool[3], 8'd0, dhrt_pkg::OC_WHITE, 1'b0,
             16'd0, 16'd0, 16'd0);
        send(dhrt_pkg::REQ_QUERY, key_pool[0], 8'd0, dhrt_pkg::OC_WHITE, 1'b0,
             16'd0, 16'd0, 16'd0);
        send(dhrt_pkg::REQ_QUERY, key_pool[1], 8'd0, dhrt_pkg::OC_WHITE, 1'b0,
             16'd0, 16'd0, 16'd0);
        send(dhrt_pkg::REQ_QUERY, key_pool[2], 8'd0, dhrt_pkg::OC_WHITE, 1'b0,
             16'd0, 16'd0, 16'd0);
        send(dhrt_pkg::REQ_QUERY, 64'h1234_5678_9ABC_DEF0, 8'd0, dhrt_pkg::OC_WHITE, 1'b0,
             16'd0, 16'd0, 16'd0);
        send(dhrt_pkg::REQ_UNKNOWN, key_pool[0], 8'd0, dhrt_pkg::OC_WHITE, 1'b1,
             16'hFFFF, 16'hFFFF, 16'hFFFF);

        // random phases through several table sizes and depth limits
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            write_reg(dhrt_pkg::CFG_BITS, phase_bits[ph]);
            write_reg(dhrt_pkg::CFG_PLY, phase_ply[ph]);
            cur_ply_limit = phase_ply[ph];
            for (int i = 0; i < 215; i++) random_request();
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
